// File: rtl/color_path_centroid_steering_defines.svh
// Assertion macros shared by the modules of the path centroid steering block.
// Depends on nothing; each user supplies its own clock and reset names.
`ifndef COLOR_PATH_CENTROID_STEERING_DEFINES_SVH
`define COLOR_PATH_CENTROID_STEERING_DEFINES_SVH

// Condition must never hold outside reset.
`define CPS_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: never");

// Antecedent in one cycle implies consequent in the next.
`define CPS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next");

// Antecedent implies consequent in the same cycle.
`define CPS_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same");

`endif

// File: rtl/cps_pkg.sv
// Shared types and constants of the path centroid steering block.
// Depends on nothing.
package cps_pkg;

  localparam int unsigned BAND_EXTRA_ROWS = 20;
  localparam int unsigned DIM_BITS        = 12;
  localparam int unsigned COUNT_BITS      = 17;
  localparam int unsigned SUM_BITS        = 29;
  localparam int unsigned HSV_FRAC        = 12;
  localparam int unsigned STEP_BITS       = 5;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_COLLISION_MM = 3'd2,
    REG_LEFT_COL     = 3'd3,
    REG_RIGHT_COL    = 3'd4,
    REG_HUE_LOW      = 3'd5,
    REG_HUE_HIGH     = 3'd6,
    REG_SAT_VAL_MIN  = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    OBST_NONE  = 2'd0,
    OBST_RIGHT = 2'd1,
    OBST_LEFT  = 2'd2,
    OBST_AHEAD = 2'd3
  } obst_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_DSTART,
    ST_DIV,
    ST_STEER,
    ST_SONAR
  } state_t;

  typedef struct packed {
    logic capture;
    logic p1;
    logic p2;
    logic p3;
    logic div_start;
    logic div_step;
    logic load_steer;
    logic load_sonar;
  } cmd_t;

  typedef struct packed {
    logic sonar;
    logic frame_end;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/cps_if.sv
// Valid/ready channel interfaces for pixel/sonar items and reports.
// Depends on nothing.
interface cps_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [12:0] range_left;
  logic [12:0] range_center;
  logic [12:0] range_right;
  modport source (output valid, req_type, blue, green, red, range_left, range_center,
                  range_right, input ready);
  modport sink (input valid, req_type, blue, green, red, range_left, range_center,
                range_right, output ready);
endinterface

interface cps_out_if;
  logic               valid;
  logic               ready;
  logic               report_kind;
  logic signed [11:0] angular_milli;
  logic [7:0]         linear_milli;
  logic [11:0]        centroid_col;
  logic               path_seen;
  logic [1:0]         obstacle_code;
  modport source (output valid, report_kind, angular_milli, linear_milli, centroid_col,
                  path_seen, obstacle_code, input ready);
  modport sink (input valid, report_kind, angular_milli, linear_milli, centroid_col,
                path_seen, obstacle_code, output ready);
endinterface

// File: rtl/cps_ctrl.sv
// Controller state machine: sequences pixel stages, centroid division, reports.
// Depends on cps_pkg.
module cps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cps_pkg::status_t status,
  output cps_pkg::cmd_t    cmd
);

  cps_pkg::state_t state, state_next;
  logic [cps_pkg::STEP_BITS-1:0] step, step_next;
  logic div_last;

  assign div_last = (step == cps_pkg::STEP_BITS'(cps_pkg::SUM_BITS - 1));

  // advance state and division step count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cps_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      cps_pkg::ST_IDLE: begin
        if (in_valid) state_next = status.sonar ? cps_pkg::ST_SONAR : cps_pkg::ST_P1;
      end
      cps_pkg::ST_P1: state_next = cps_pkg::ST_P2;
      cps_pkg::ST_P2: state_next = cps_pkg::ST_P3;
      cps_pkg::ST_P3: begin
        state_next = status.frame_end ? cps_pkg::ST_DSTART : cps_pkg::ST_IDLE;
      end
      cps_pkg::ST_DSTART: begin
        state_next = cps_pkg::ST_DIV;
        step_next  = '0;
      end
      cps_pkg::ST_DIV: begin
        step_next = step + 1'b1;
        if (div_last) state_next = cps_pkg::ST_STEER;
      end
      cps_pkg::ST_STEER: if (!status.out_busy) state_next = cps_pkg::ST_IDLE;
      cps_pkg::ST_SONAR: if (!status.out_busy) state_next = cps_pkg::ST_IDLE;
      default: state_next = cps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      cps_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      cps_pkg::ST_P1:     cmd.p1 = 1'b1;
      cps_pkg::ST_P2:     cmd.p2 = 1'b1;
      cps_pkg::ST_P3:     cmd.p3 = 1'b1;
      cps_pkg::ST_DSTART: cmd.div_start = 1'b1;
      cps_pkg::ST_DIV:    cmd.div_step = 1'b1;
      cps_pkg::ST_STEER:  cmd.load_steer = !status.out_busy;
      cps_pkg::ST_SONAR:  cmd.load_sonar = !status.out_busy;
      default: ;
    endcase
  end

endmodule

// File: rtl/cps_dp.sv
// Datapath: config registers, HSV match, band accumulators, divider, output register.
// Depends on cps_pkg, cps_if and the assertion macro header.
`include "color_path_centroid_steering_defines.svh"
module cps_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [12:0]      cfg_data,
  cps_in_if.sink           pixel_in,
  cps_out_if.source        report_out,
  input  cps_pkg::cmd_t    cmd,
  output cps_pkg::status_t status
);

  localparam int unsigned DW = cps_pkg::DIM_BITS;
  localparam int unsigned CW = cps_pkg::COUNT_BITS;
  localparam int unsigned SW = cps_pkg::SUM_BITS;
  localparam int unsigned FR = cps_pkg::HSV_FRAC;

  // configuration registers
  logic [11:0] frame_width, frame_height, col_lo_bound, col_hi_bound;
  logic [12:0] collision_mm;
  logic [7:0]  hue_low, hue_high, sat_val_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd640;
      frame_height <= 12'd480;
      collision_mm <= 13'd2500;
      col_lo_bound <= 12'd100;
      col_hi_bound <= 12'd540;
      hue_low      <= 8'd20;
      hue_high     <= 8'd30;
      sat_val_min  <= 8'd100;
    end else if (cfg_write) begin
      unique case (cps_pkg::reg_index_t'(cfg_index))
        cps_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[11:0];
        cps_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[11:0];
        cps_pkg::REG_COLLISION_MM: collision_mm <= cfg_data;
        cps_pkg::REG_LEFT_COL:     col_lo_bound <= cfg_data[11:0];
        cps_pkg::REG_RIGHT_COL:    col_hi_bound <= cfg_data[11:0];
        cps_pkg::REG_HUE_LOW:      hue_low      <= cfg_data[7:0];
        cps_pkg::REG_HUE_HIGH:     hue_high     <= cfg_data[7:0];
        cps_pkg::REG_SAT_VAL_MIN:  sat_val_min  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // reciprocal tables, rounded to nearest
  logic [19:0] sdiv_tab [256];
  logic [16:0] hdiv_tab [256];
  assign sdiv_tab[0] = '0;
  assign hdiv_tab[0] = '0;
  for (genvar i = 1; i < 256; i++) begin : g_tab
    localparam int unsigned SD = (2 * (255 << 12) + i) / (2 * i);
    localparam int unsigned HD = (2 * (30 << 12) + i) / (2 * i);
    assign sdiv_tab[i] = 20'(SD);
    assign hdiv_tab[i] = 17'(HD);
  end

  // capture the accepted item
  logic [7:0]  b, g, r;
  logic [12:0] rl, rc, rr;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      b  <= pixel_in.blue;
      g  <= pixel_in.green;
      r  <= pixel_in.red;
      rl <= pixel_in.range_left;
      rc <= pixel_in.range_center;
      rr <= pixel_in.range_right;
    end
  end

  // stage 1: max, min, hue numerator, table lookup
  logic [7:0] vmax, vmin, vdiff;
  logic signed [11:0] hnum;
  logic [7:0]  v1, d1;
  logic signed [11:0] hnum1;
  logic [19:0] sdiv1;
  logic [16:0] hdiv1;

  always_comb begin
    vmax = b;
    if (g > vmax) vmax = g;
    if (r > vmax) vmax = r;
    vmin = b;
    if (g < vmin) vmin = g;
    if (r < vmin) vmin = r;
    vdiff = vmax - vmin;
    priority if (vmax == r) hnum = 12'(signed'({4'd0, g})) - 12'(signed'({4'd0, b}));
    else if (vmax == g) hnum = 12'(signed'({4'd0, b})) - 12'(signed'({4'd0, r}))
                             + 12'(signed'({3'd0, vdiff, 1'b0}));
    else hnum = 12'(signed'({4'd0, r})) - 12'(signed'({4'd0, g}))
              + 12'(signed'({2'd0, vdiff, 2'b0}));
  end

  always_ff @(posedge clk) begin
    if (cmd.p1) begin
      v1    <= vmax;
      d1    <= vdiff;
      hnum1 <= hnum;
      sdiv1 <= sdiv_tab[vmax];
      hdiv1 <= hdiv_tab[vdiff];
    end
  end

  // stage 2: scale by reciprocals
  logic [27:0] sprod;
  logic signed [29:0] hprod;
  logic [7:0]  v2;
  always_ff @(posedge clk) begin
    if (cmd.p2) begin
      sprod <= d1 * sdiv1;
      hprod <= 30'(hnum1) * 30'(signed'({1'b0, hdiv1}));
      v2    <= v1;
    end
  end

  // stage 3: round, wrap hue, test color
  logic [16:0] sat;
  logic signed [17:0] hue, hue_w;
  logic [28:0] sround;
  logic signed [29:0] hround;
  logic pix_match;
  always_comb begin
    sround = {1'b0, sprod} + 29'(1 << (FR - 1));
    sat    = sround[28:12];
    hround = hprod + 30'sd2048;
    hue    = 18'(hround >>> FR);
    hue_w  = (hue < 0) ? hue + 18'sd180 : hue;
    pix_match = (hue_w >= 18'(signed'({1'b0, hue_low}))) &&
                (hue_w <= 18'(signed'({1'b0, hue_high}))) &&
                (sat >= 17'(sat_val_min)) && (v2 >= sat_val_min);
  end

  // raster counters and band window
  logic [DW-1:0] col, row;
  logic [CW-1:0] match_count;
  logic [SW-1:0] column_sum;
  logic [11:0] w_eff, h_eff;
  logic [13:0] band_top;
  logic [14:0] band_bot;
  logic in_band, row_end, frame_end;
  logic [SW:0] sum_add;

  always_comb begin
    w_eff     = (frame_width == '0) ? 12'd1 : frame_width;
    h_eff     = (frame_height == '0) ? 12'd1 : frame_height;
    band_top  = 14'((16'(h_eff) * 16'd3) >> 2);
    band_bot  = 15'(band_top) + 15'(cps_pkg::BAND_EXTRA_ROWS);
    in_band   = (14'(row) >= band_top) && (15'(row) <= band_bot);
    row_end   = (13'(col) + 13'd1) >= 13'(w_eff);
    frame_end = row_end && ((13'(row) + 13'd1) >= 13'(h_eff));
    sum_add   = {1'b0, column_sum} + (SW+1)'(col);
  end

  // accumulate, advance counters; clear once the command is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      match_count <= '0;
      column_sum  <= '0;
    end else if (cmd.load_steer) begin
      match_count <= '0;
      column_sum  <= '0;
    end else if (cmd.p3) begin
      if (in_band && pix_match) begin
        if (match_count != '1) match_count <= match_count + 1'b1;
        column_sum <= sum_add[SW] ? '1 : sum_add[SW-1:0];
      end
      if (!row_end) col <= col + 1'b1;
      else begin
        col <= '0;
        row <= frame_end ? '0 : row + 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per step
  logic [CW:0]   rem;
  logic [SW-1:0] quo;
  logic [CW+1:0] trial;
  assign trial = {rem, quo[SW-1]} - {2'b0, match_count};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      quo <= column_sum;
    end else if (cmd.div_step) begin
      if (!trial[CW+1]) rem <= trial[CW:0];
      else rem <= {rem[CW-1:0], quo[SW-1]};
      quo <= {quo[SW-2:0], !trial[CW+1]};
    end
  end

  // steering decision
  logic [1:0] obstacle_state, obst_new;
  logic seen, near_edge;
  logic [SW-1:0] cx;
  logic signed [SW+1:0] err_full;
  logic signed [11:0] err, ang;
  logic [7:0] lin;

  always_comb begin
    seen      = (match_count != '0);
    cx        = seen ? quo : '0;
    err_full  = signed'({2'b0, cx}) - (SW+2)'(w_eff >> 1);
    if (err_full > 2047) err = 12'sd2047;
    else if (err_full < -2048) err = -12'sd2048;
    else err = err_full[11:0];
    near_edge = (cx <= SW'(col_lo_bound)) || (cx >= SW'(col_hi_bound));
    ang = '0;
    lin = '0;
    if (seen) begin
      priority if (obstacle_state == cps_pkg::OBST_RIGHT) begin
        ang = -12'sd200;
        lin = (cx > SW'(col_hi_bound)) ? 8'd200 : 8'd0;
      end else if (obstacle_state == cps_pkg::OBST_LEFT) begin
        ang = 12'sd200;
        lin = (cx < SW'(col_lo_bound)) ? 8'd200 : 8'd0;
      end else if (obstacle_state == cps_pkg::OBST_AHEAD && near_edge) begin
        ang = err;
      end else if (obstacle_state == cps_pkg::OBST_AHEAD) begin
        ang = (err < 0) ? -12'sd200 : 12'sd200;
        lin = 8'd100;
      end else if (near_edge) begin
        ang = err;
      end else begin
        lin = 8'd200;
      end
    end else begin
      unique case (obstacle_state)
        cps_pkg::OBST_RIGHT: begin ang = -12'sd200; lin = 8'd200; end
        cps_pkg::OBST_LEFT:  begin ang = 12'sd200;  lin = 8'd200; end
        cps_pkg::OBST_AHEAD: ang = 12'sd200;
        default:             ang = -12'sd200;
      endcase
    end
    priority if (rl < collision_mm) obst_new = cps_pkg::OBST_RIGHT;
    else if (rr < collision_mm) obst_new = cps_pkg::OBST_LEFT;
    else if (rc < collision_mm) obst_new = cps_pkg::OBST_AHEAD;
    else obst_new = cps_pkg::OBST_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) obstacle_state <= cps_pkg::OBST_NONE;
    else if (cmd.load_sonar) obstacle_state <= obst_new;
  end

  // output register; hold until transfer
  logic out_valid;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_steer || cmd.load_sonar) out_valid <= 1'b1;
    else if (report_out.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_steer) begin
      report_out.report_kind   <= 1'b0;
      report_out.angular_milli <= ang;
      report_out.linear_milli  <= lin;
      report_out.centroid_col  <= cx[11:0];
      report_out.path_seen     <= seen;
      report_out.obstacle_code <= obstacle_state;
    end else if (cmd.load_sonar) begin
      report_out.report_kind   <= 1'b1;
      report_out.angular_milli <= '0;
      report_out.linear_milli  <= '0;
      report_out.centroid_col  <= '0;
      report_out.path_seen     <= 1'b0;
      report_out.obstacle_code <= obst_new;
    end
  end

  assign report_out.valid = out_valid;
  assign status.sonar     = pixel_in.req_type;
  assign status.frame_end = frame_end;
  assign status.out_busy  = out_valid && !report_out.ready;

  `CPS_ASSERT_NEVER(a_one_load, clk, rst, cmd.load_steer && cmd.load_sonar)
  `CPS_ASSERT_SAME(a_load_free, clk, rst, cmd.load_steer || cmd.load_sonar,
                   !out_valid || report_out.ready)
  `CPS_ASSERT_NEXT(a_clear, clk, rst, cmd.load_steer, match_count == '0 && column_sum == '0)

endmodule

// File: rtl/color_path_centroid_steering.sv
// Top level of the yellow path centroid steering block.
// Depends on cps_pkg, cps_if, cps_ctrl and cps_dp.
//
// A pixel item runs through these steps before the next item can be taken
// (accept, max/min with reciprocal lookup, multiply, round and accumulate).
// The last pixel of a frame adds the bit-serial centroid division (29 quotient
// bits, one per cycle) and the steering load, plus any wait for the output
// register to drain; a sonar item goes from accept to its report load. The
// output register lets the result wait while the next item is accepted.
module color_path_centroid_steering (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [12:0] cfg_data,
  cps_in_if.sink     pixel_in,
  cps_out_if.source  report_out
);

  cps_pkg::cmd_t    cmd;
  cps_pkg::status_t status;
  logic             ctrl_ready;

  cps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_in.valid),
    .in_ready (ctrl_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // accept input only while the controller is idle
  assign pixel_in.ready = ctrl_ready;

  cps_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_in   (pixel_in),
    .report_out (report_out),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

// File: verif/cps_tb_pkg.sv
// Helper types for the path centroid steering testbench: one input transfer and one report.
// Depends on cps_pkg.
package cps_tb_pkg;
  import cps_pkg::*;

  typedef struct {
    logic        req_type;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [12:0] range_left;
    logic [12:0] range_center;
    logic [12:0] range_right;
  } item_t;

  typedef struct {
    logic               report_kind;
    logic signed [11:0] angular_milli;
    logic [7:0]         linear_milli;
    logic [11:0]        centroid_col;
    logic               path_seen;
    logic [1:0]         obstacle_code;
  } report_t;
endpackage

// File: verif/cps_tb_if.sv
// Testbench-side copies of the channel interfaces are not needed; the RTL interfaces
// from cps_if are used directly. This file only holds the cycle limit constant.
// Depends on nothing.
package cps_tb_limits;
  localparam int unsigned CYCLE_LIMIT = 2000000;
endpackage

// File: verif/color_path_centroid_steering_tb.sv
// Self-checking testbench of the path centroid steering block: random pixel frames and
// sonar items go in, a local predictor computes the reports. Depends on cps_pkg, cps_if.
module color_path_centroid_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cps_pkg::*;
  import cps_tb_pkg::*;
  import cps_tb_limits::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_data;

  cps_in_if  pixel_in();
  cps_out_if report_out();

  color_path_centroid_steering dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixel_in(pixel_in), .report_out(report_out)
  );

  // predictor copy of the configuration and state
  logic [11:0] m_width, m_height, m_left, m_right;
  logic [12:0] m_coll;
  logic [7:0]  m_hlo, m_hhi, m_svmin;
  logic [11:0] m_col, m_row;
  logic [16:0] m_count;
  logic [28:0] m_sum;
  logic [1:0]  m_obst;

  item_t   pending_items[$];
  report_t expected_reports[$];
  int      mismatches = 0;
  int      cycle_count;
  logic    all_sent;
  logic    in_done;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // hue/saturation band test in the block's fixed-point form
  function automatic bit color_in_band(int b, int g, int r);
    int v, mn, diff, s, h, sdiv, hdiv;
    v = b; mn = b;
    if (g > v) v = g;
    if (r > v) v = r;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    diff = v - mn;
    sdiv = v ? (2 * (255 << HSV_FRAC) + v) / (2 * v) : 0;
    hdiv = diff ? (2 * (30 << HSV_FRAC) + diff) / (2 * diff) : 0;
    s = (diff * sdiv + (1 << (HSV_FRAC - 1))) >>> HSV_FRAC;
    if (v == r) h = g - b;
    else if (v == g) h = b - r + 2 * diff;
    else h = r - g + 4 * diff;
    h = h * hdiv + (1 << (HSV_FRAC - 1));
    h = h >>> HSV_FRAC;
    if (h < 0) h += 180;
    return h >= m_hlo && h <= m_hhi && s >= m_svmin && v >= m_svmin;
  endfunction

  function automatic report_t steering_command();
    report_t rp;
    int ang, lin, cx, err, w, lft, rgt;
    bit seen;
    ang = 0; lin = 0; cx = 0;
    w = (m_width == 0) ? 1 : m_width;
    seen = m_count != 0;
    lft = m_left; rgt = m_right;
    if (seen) begin
      cx = m_sum / m_count;
      err = cx - w / 2;
      if (err > 2047) err = 2047;
      if (err < -2048) err = -2048;
      if (m_obst == OBST_RIGHT) begin
        ang = -200; lin = (cx > rgt) ? 200 : 0;
      end else if (m_obst == OBST_LEFT) begin
        ang = 200; lin = (cx < lft) ? 200 : 0;
      end else if (m_obst == OBST_AHEAD && (cx <= lft || cx >= rgt)) begin
        ang = err;
      end else if (m_obst == OBST_AHEAD) begin
        ang = (err < 0) ? -200 : 200; lin = 100;
      end else if (cx <= lft || cx >= rgt) begin
        ang = err;
      end else begin
        lin = 200;
      end
    end else begin
      case (m_obst)
        OBST_RIGHT: begin ang = -200; lin = 200; end
        OBST_LEFT:  begin ang = 200; lin = 200; end
        OBST_AHEAD: ang = 200;
        default:    ang = -200;
      endcase
    end
    rp.report_kind   = 1'b0;
    rp.angular_milli = ang[11:0];
    rp.linear_milli  = lin[7:0];
    rp.centroid_col  = cx[11:0];
    rp.path_seen     = seen;
    rp.obstacle_code = m_obst;
    return rp;
  endfunction

  // advance the predictor by one accepted transfer
  task automatic predict_report(input item_t it);
    report_t rp;
    int w, hgt, top;
    if (it.req_type) begin
      if (it.range_left < m_coll) m_obst = OBST_RIGHT;
      else if (it.range_right < m_coll) m_obst = OBST_LEFT;
      else if (it.range_center < m_coll) m_obst = OBST_AHEAD;
      else m_obst = OBST_NONE;
      rp.report_kind = 1'b1; rp.angular_milli = '0; rp.linear_milli = '0;
      rp.centroid_col = '0; rp.path_seen = 1'b0; rp.obstacle_code = m_obst;
      expected_reports.push_back(rp);
      return;
    end
    w = (m_width == 0) ? 1 : m_width;
    hgt = (m_height == 0) ? 1 : m_height;
    top = 3 * hgt / 4;
    if (m_row >= top && m_row <= top + BAND_EXTRA_ROWS &&
        color_in_band(it.blue, it.green, it.red)) begin
      if (m_count != 17'h1FFFF) m_count++;
      if ({3'b0, m_sum} + m_col > 32'h1FFFFFFF) m_sum = 29'h1FFFFFFF;
      else m_sum = m_sum + m_col;
    end
    if (m_col + 1 < w) begin
      m_col = m_col + 1;
      return;
    end
    m_col = 0;
    if (m_row + 1 < hgt) begin
      m_row = m_row + 1;
      return;
    end
    expected_reports.push_back(steering_command());
    m_row = 0; m_count = 0; m_sum = 0;
  endtask

  function automatic item_t random_pixel();
    item_t it;
    int pick;
    it.req_type = 1'b0;
    pick = $urandom_range(0, 3);
    // bias toward yellow so the band actually matches
    if (pick < 2) begin
      it.red = $urandom_range(150, 255); it.green = $urandom_range(120, 255);
      it.blue = $urandom_range(0, 60);
    end else begin
      it.red = $urandom; it.green = $urandom; it.blue = $urandom;
    end
    it.range_left = $urandom; it.range_center = $urandom; it.range_right = $urandom;
    return it;
  endfunction

  function automatic item_t random_sonar();
    item_t it;
    it.req_type = 1'b1;
    it.range_left = $urandom; it.range_center = $urandom; it.range_right = $urandom;
    if ($urandom_range(0, 1)) it.range_left = $urandom_range(0, 3000);
    if ($urandom_range(0, 1)) it.range_right = $urandom_range(0, 3000);
    if ($urandom_range(0, 1)) it.range_center = $urandom_range(0, 3000);
    it.blue = $urandom; it.green = $urandom; it.red = $urandom;
    return it;
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [12:0] val);
    @(negedge clk);
    cfg_write = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  m_width = val[11:0];
      REG_FRAME_HEIGHT: m_height = val[11:0];
      REG_COLLISION_MM: m_coll = val;
      REG_LEFT_COL:     m_left = val[11:0];
      REG_RIGHT_COL:    m_right = val[11:0];
      REG_HUE_LOW:      m_hlo = val[7:0];
      REG_HUE_HIGH:     m_hhi = val[7:0];
      default:          m_svmin = val[7:0];
    endcase
  endtask

  // hold until the block has drained, then allow in-flight frame-end work to finish
  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic queue_frames(input int n_frames, input int sonar_pct);
    int n;
    n = ((m_width == 0) ? 1 : m_width) * ((m_height == 0) ? 1 : m_height) * n_frames;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < sonar_pct) pending_items.push_back(random_sonar());
      pending_items.push_back(random_pixel());
    end
  endtask

  // stimulus: directed items first, then random phases across settings
  initial begin
    item_t it;
    cfg_write = 1'b0; cfg_index = REG_FRAME_WIDTH; cfg_data = '0;
    all_sent = 1'b0;
    m_width = 640; m_height = 480; m_coll = 2500; m_left = 100; m_right = 540;
    m_hlo = 20; m_hhi = 30; m_svmin = 100;
    m_col = 0; m_row = 0; m_count = 0; m_sum = 0; m_obst = OBST_NONE;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // tiny 4x4 frame with extreme and yellow colors
    write_reg(REG_FRAME_WIDTH, 13'd4);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    write_reg(REG_LEFT_COL, 13'd0);
    write_reg(REG_RIGHT_COL, 13'd3);
    for (int i = 0; i < 16; i++) begin
      it = random_pixel();
      case (i % 4)
        0: begin it.blue = 0; it.green = 0; it.red = 0; end
        1: begin it.blue = 255; it.green = 255; it.red = 255; end
        2: begin it.blue = 0; it.green = 220; it.red = 255; end
        default: begin it.blue = 0; it.green = 0; it.red = 255; end
      endcase
      pending_items.push_back(it);
    end
    // sonar priorities and extremes
    for (int i = 0; i < 6; i++) begin
      it = random_sonar();
      it.range_left = (i == 0) ? 13'd0 : 13'h1FFF;
      it.range_right = (i == 1) ? 13'd0 : 13'h1FFF;
      it.range_center = (i == 2) ? 13'd0 : ((i == 5) ? 13'd2499 : 13'h1FFF);
      pending_items.push_back(it);
    end
    wait_drained();

    // zero size and wide hue band
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    write_reg(REG_HUE_LOW, 13'd0);
    write_reg(REG_HUE_HIGH, 13'd179);
    write_reg(REG_SAT_VAL_MIN, 13'd0);
    write_reg(REG_COLLISION_MM, 13'd0);
    queue_frames(6, 20);
    wait_drained();

    // small frames, default-like thresholds
    write_reg(REG_FRAME_WIDTH, 13'd8);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    write_reg(REG_HUE_LOW, 13'd20);
    write_reg(REG_HUE_HIGH, 13'd35);
    write_reg(REG_SAT_VAL_MIN, 13'd100);
    write_reg(REG_COLLISION_MM, 13'd2500);
    write_reg(REG_LEFT_COL, 13'd2);
    write_reg(REG_RIGHT_COL, 13'd5);
    queue_frames(8, 8);
    wait_drained();

    // wide single-row frame with the path near the right edge
    write_reg(REG_FRAME_WIDTH, 13'd360);
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    write_reg(REG_LEFT_COL, 13'd4095);
    write_reg(REG_RIGHT_COL, 13'd0);
    write_reg(REG_COLLISION_MM, 13'h1FFF);
    write_reg(REG_SAT_VAL_MIN, 13'd255);
    for (int i = 0; i < 360; i++) begin
      it = random_pixel();
      if (i > 300) begin it.blue = 0; it.green = 255; it.red = 255; end
      pending_items.push_back(it);
    end
    wait_drained();

    // back to small frames, limits in the middle
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    write_reg(REG_LEFT_COL, 13'd1);
    write_reg(REG_RIGHT_COL, 13'd4);
    write_reg(REG_SAT_VAL_MIN, 13'd60);
    write_reg(REG_COLLISION_MM, 13'd2000);
    queue_frames(20, 15);
    wait_drained();
    all_sent = 1'b1;
  end

  task automatic it_drive(input item_t it);
    pixel_in.req_type <= it.req_type;
    pixel_in.blue <= it.blue;
    pixel_in.green <= it.green;
    pixel_in.red <= it.red;
    pixel_in.range_left <= it.range_left;
    pixel_in.range_center <= it.range_center;
    pixel_in.range_right <= it.range_right;
  endtask

  // driver: bursts with random gaps, advance only after a transfer
  int  burst_left;
  int  gap_left;
  always @(negedge clk) begin
    if (rst) begin
      pixel_in.valid <= 1'b0;
      pixel_in.req_type <= 1'b0;
      pixel_in.blue <= '0;
      pixel_in.green <= '0;
      pixel_in.red <= '0;
      pixel_in.range_left <= '0;
      pixel_in.range_center <= '0;
      pixel_in.range_right <= '0;
      burst_left <= $urandom_range(1, 20);
      gap_left <= 0;
    end else if (!pixel_in.valid || in_done) begin
      if (pending_items.size() != 0 && gap_left == 0) begin
        it_drive(pending_items[0]);
        pixel_in.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        pixel_in.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // receiver stall pattern: phases of always-ready and random stalls
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 300;
    if (rst) report_out.ready <= 1'b0;
    else if (stall_phase < 100) report_out.ready <= 1'b1;
    else report_out.ready <= ($urandom_range(0, 2) != 0);
  end

  // monitor: predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    report_t exp_rp;
    if (rst) begin
      cycle_count <= 0;
      in_done <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      in_done <= pixel_in.valid && pixel_in.ready;
      if (pixel_in.valid && pixel_in.ready) begin
        predict_report(pending_items.pop_front());
      end
      if (report_out.valid && report_out.ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected report at cycle %0d", cycle_count);
        end else begin
          exp_rp = expected_reports.pop_front();
          if (report_out.report_kind !== exp_rp.report_kind ||
              report_out.angular_milli !== exp_rp.angular_milli ||
              report_out.linear_milli !== exp_rp.linear_milli ||
              report_out.centroid_col !== exp_rp.centroid_col ||
              report_out.path_seen !== exp_rp.path_seen ||
              report_out.obstacle_code !== exp_rp.obstacle_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                exp_rp.report_kind, exp_rp.angular_milli, exp_rp.linear_milli,
                exp_rp.centroid_col, exp_rp.path_seen, exp_rp.obstacle_code,
                report_out.report_kind, report_out.angular_milli, report_out.linear_milli,
                report_out.centroid_col, report_out.path_seen, report_out.obstacle_code);
          end
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    fork
      begin
        wait (all_sent === 1'b1);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
          $display("Testbench completed without errors");
        else
          $display("Testbench completed WITH ERRORS");
        $finish;
      end
      begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    join
  end
endmodule
